FILE: hw/rtl/ppti_pkg.sv
// Shared types and constants for the path progress time interpolator.
package ppti_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam int SQRT_STEPS  = 34;
    localparam int PDIV_STEPS  = 16;
    localparam int IDIV_STEPS  = 32;
    localparam int SQ_TERMS    = 3;
    localparam int DOT_TERMS   = 6;

    typedef enum logic [21:0] {
        S_IDLE   = 22'b0000000000000000000001,
        S_FETCH0 = 22'b0000000000000000000010,
        S_BASE   = 22'b0000000000000000000100,
        S_FETCHL = 22'b0000000000000000001000,
        S_LAST   = 22'b0000000000000000010000,
        S_LEN    = 22'b0000000000000000100000,
        S_CHECK  = 22'b0000000000000001000000,
        S_PDIV   = 22'b0000000000000010000000,
        S_TOTS   = 22'b0000000000000100000000,
        S_TOTR   = 22'b0000000000001000000000,
        S_PD     = 22'b0000000000010000000000,
        S_PD2    = 22'b0000000000100000000000,
        S_FI     = 22'b0000000001000000000000,
        S_DI     = 22'b0000000010000000000000,
        S_SQ     = 22'b0000000100000000000000,
        S_DS     = 22'b0000001000000000000000,
        S_DR     = 22'b0000010000000000000000,
        S_CMP    = 22'b0000100000000000000000,
        S_IM0    = 22'b0001000000000000000000,
        S_IM1    = 22'b0010000000000000000000,
        S_IM2    = 22'b0100000000000000000000,
        S_IDIV   = 22'b1000000000000000000000
    } state_t;

    function automatic logic [32:0] mag33(logic [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(~v + 33'd1) : v;
        return r;
    endfunction

    function automatic logic [32:0] diff33(logic [31:0] a, logic [31:0] b);
        logic [32:0] r;
        r = {a[31], a} - {b[31], b};
        return r;
    endfunction

endpackage

FILE: hw/rtl/path_progress_time_interpolator.sv
// Top level: path point table and sequenced progress-to-time interpolator.
//
// Load items (opcode 0) write one table entry {pos_x, pos_y, pos_z, stamp_time}
// at entry_index in the cycle they are accepted; busy stays low.
// Query items (opcode 1) project the tool position onto the first-to-last line,
// walk the table and return time_out, progress and status with a one-cycle
// done strobe. An item is accepted when start is high and busy is low.
// A query holds busy high through setup (shorter when the progress clamps
// to 0 or 1, as no division is needed), the walk over the points and the
// final interpolation. A zero-length path answers early with status 1.
// done rises in the cycle in which busy falls. The sequencer uses a single
// shared unit set in turn: one multiplier, one bit-per-cycle divider and
// one two-bits-per-cycle square root. A path with under two points answers
// with status 1 in the cycle after it is accepted.
// point_count is written over the APB port at byte address 0.
// Reset clears the sequencer, the count and the strobe; table contents are
// undefined until written. Results hold until replaced; done lasts one cycle.
module path_progress_time_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [5:0]  entry_index,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] stamp_time,
    output logic        done,
    output logic [31:0] time_out,
    output logic [16:0] progress,
    output logic        status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = $clog2(MAX_POINTS + 1);

    ppti_pkg::state_t state_reg;

    logic [127:0]  mem_reg [MAX_POINTS];
    logic [127:0]  rd_reg;
    logic [AW-1:0] addr_reg;
    logic [6:0]    count_reg;
    logic [IW-1:0] n_reg;
    logic [IW-1:0] i_reg;
    logic [5:0]    cnt_reg;

    logic [31:0] x0_reg, y0_reg, z0_reg, qx_reg, qy_reg, qz_reg;
    logic [32:0] ax_reg, ay_reg, az_reg, dx_reg, dy_reg, dz_reg;
    logic [31:0] tprev_reg, tcur_reg, tlast_reg;
    logic [65:0] len2_reg, pos_reg, neg_reg, acc_reg;
    logic [16:0] p_reg;
    logic [33:0] total_reg, cur_reg, prev_reg;
    logic [50:0] pd_reg;
    logic [49:0] num_reg, den_reg;
    logic [31:0] dt_reg;
    logic        dir_reg;
    logic [63:0] lo_reg;

    logic        done_reg, status_reg;
    logic [31:0] time_out_reg;
    logic [16:0] progress_reg;

    // shared multiplier
    logic [32:0] mul_a;
    logic [33:0] mul_b;
    logic        mul_neg;
    logic [66:0] prod_reg;
    logic        prod_neg_reg;

    // shared divider
    logic [66:0] dv_rem_reg, dv_t, dv_rem_next;
    logic [65:0] dv_div_reg;
    logic [31:0] dv_low_reg, dv_q_reg, dv_q_next;

    // shared square root
    logic [67:0] sq_src_reg;
    logic [36:0] sq_rem_reg, sq_t, sq_trial;
    logic [33:0] sq_root_reg, sq_root_next;
    logic [36:0] sq_rem_next;

    logic        accept, cfg_wr, wr_ok;
    logic [IW-1:0] n_eff;
    logic [65:0] dot;
    logic [49:0] d1s, d2s, num_c;
    logic [81:0] full;

    assign accept = start && !busy;
    assign busy   = (state_reg != ppti_pkg::S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ppti_pkg::REG_POINT_COUNT) ? {25'd0, count_reg} : 32'd0;
    assign wr_ok  = (32'(entry_index) < 32'(MAX_POINTS));
    assign n_eff  = (32'(count_reg) > 32'(MAX_POINTS)) ? IW'(MAX_POINTS) : IW'(count_reg);

    assign done     = done_reg;
    assign time_out = time_out_reg;
    assign progress = progress_reg;
    assign status   = status_reg;

    assign dot  = pos_reg - neg_reg;
    assign d1s  = {prev_reg, 16'd0};
    assign d2s  = {cur_reg, 16'd0};
    assign num_c = (pd_reg > {1'b0, d1s}) ? 50'(pd_reg - {1'b0, d1s}) : 50'd0;
    assign full = {prod_reg[49:0], 32'd0} + {18'd0, lo_reg};

    always_comb
    begin
        dv_t        = {dv_rem_reg[65:0], dv_low_reg[31]};
        dv_rem_next = dv_t;
        dv_q_next   = {dv_q_reg[30:0], 1'b0};
        if (dv_t >= {1'b0, dv_div_reg})
        begin
            dv_rem_next = dv_t - {1'b0, dv_div_reg};
            dv_q_next   = {dv_q_reg[30:0], 1'b1};
        end
    end

    always_comb
    begin
        sq_t         = {sq_rem_reg[34:0], sq_src_reg[67:66]};
        sq_trial     = {1'b0, sq_root_reg, 2'b01};
        sq_rem_next  = sq_t;
        sq_root_next = {sq_root_reg[32:0], 1'b0};
        if (sq_t >= sq_trial)
        begin
            sq_rem_next  = sq_t - sq_trial;
            sq_root_next = {sq_root_reg[32:0], 1'b1};
        end
    end

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (state_reg)
            ppti_pkg::S_LEN, ppti_pkg::S_SQ:
            begin
                unique case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = ppti_pkg::mag33(dx_reg);
                        mul_b = {1'b0, ppti_pkg::mag33(dx_reg)};
                    end
                    6'd1:
                    begin
                        mul_a = ppti_pkg::mag33(dy_reg);
                        mul_b = {1'b0, ppti_pkg::mag33(dy_reg)};
                    end
                    6'd2:
                    begin
                        mul_a = ppti_pkg::mag33(dz_reg);
                        mul_b = {1'b0, ppti_pkg::mag33(dz_reg)};
                    end
                    6'd3:
                    begin
                        mul_a   = ppti_pkg::mag33(ax_reg);
                        mul_b   = {1'b0, ppti_pkg::mag33(dx_reg)};
                        mul_neg = ax_reg[32] ^ dx_reg[32];
                    end
                    6'd4:
                    begin
                        mul_a   = ppti_pkg::mag33(ay_reg);
                        mul_b   = {1'b0, ppti_pkg::mag33(dy_reg)};
                        mul_neg = ay_reg[32] ^ dy_reg[32];
                    end
                    6'd5:
                    begin
                        mul_a   = ppti_pkg::mag33(az_reg);
                        mul_b   = {1'b0, ppti_pkg::mag33(dz_reg)};
                        mul_neg = az_reg[32] ^ dz_reg[32];
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            ppti_pkg::S_PD:
            begin
                mul_a = {16'd0, p_reg};
                mul_b = total_reg;
            end
            ppti_pkg::S_IM0:
            begin
                mul_a = {1'b0, num_reg[31:0]};
                mul_b = {2'b0, dt_reg};
            end
            ppti_pkg::S_IM1:
            begin
                mul_a = {15'd0, num_reg[49:32]};
                mul_b = {2'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        prod_neg_reg <= mul_neg;
        rd_reg       <= mem_reg[addr_reg];
        if (accept && opcode == ppti_pkg::OP_LOAD && wr_ok)
        begin
            mem_reg[AW'(entry_index)] <= {stamp_time, pos_z, pos_y, pos_x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr && paddr[2] == ppti_pkg::REG_POINT_COUNT)
        begin
            count_reg <= pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ppti_pkg::S_IDLE;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            n_reg        <= '0;
            addr_reg     <= '0;
            status_reg   <= 1'b0;
            time_out_reg <= '0;
            progress_reg <= '0;
            qx_reg       <= '0;
            qy_reg       <= '0;
            qz_reg       <= '0;
            x0_reg       <= '0;
            y0_reg       <= '0;
            z0_reg       <= '0;
            ax_reg       <= '0;
            ay_reg       <= '0;
            az_reg       <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dz_reg       <= '0;
            tprev_reg    <= '0;
            tcur_reg     <= '0;
            tlast_reg    <= '0;
            len2_reg     <= '0;
            pos_reg      <= '0;
            neg_reg      <= '0;
            acc_reg      <= '0;
            p_reg        <= '0;
            total_reg    <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            pd_reg       <= '0;
            num_reg      <= '0;
            den_reg      <= '0;
            dt_reg       <= '0;
            dir_reg      <= 1'b0;
            lo_reg       <= '0;
            dv_rem_reg   <= '0;
            dv_div_reg   <= '0;
            dv_low_reg   <= '0;
            dv_q_reg     <= '0;
            sq_src_reg   <= '0;
            sq_rem_reg   <= '0;
            sq_root_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ppti_pkg::S_IDLE:
                begin
                    if (accept && opcode == ppti_pkg::OP_QUERY)
                    begin
                        qx_reg <= pos_x;
                        qy_reg <= pos_y;
                        qz_reg <= pos_z;
                        n_reg  <= n_eff;
                        addr_reg <= '0;
                        if (n_eff < IW'(2))
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= 1'b1;
                            time_out_reg <= '0;
                            progress_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ppti_pkg::S_FETCH0;
                        end
                    end
                end
                ppti_pkg::S_FETCH0:
                begin
                    state_reg <= ppti_pkg::S_BASE;
                end
                ppti_pkg::S_BASE:
                begin
                    x0_reg    <= rd_reg[31:0];
                    y0_reg    <= rd_reg[63:32];
                    z0_reg    <= rd_reg[95:64];
                    tprev_reg <= rd_reg[127:96];
                    ax_reg    <= ppti_pkg::diff33(qx_reg, rd_reg[31:0]);
                    ay_reg    <= ppti_pkg::diff33(qy_reg, rd_reg[63:32]);
                    az_reg    <= ppti_pkg::diff33(qz_reg, rd_reg[95:64]);
                    addr_reg  <= AW'(n_reg - IW'(1));
                    state_reg <= ppti_pkg::S_FETCHL;
                end
                ppti_pkg::S_FETCHL:
                begin
                    state_reg <= ppti_pkg::S_LAST;
                end
                ppti_pkg::S_LAST:
                begin
                    dx_reg    <= ppti_pkg::diff33(rd_reg[31:0], x0_reg);
                    dy_reg    <= ppti_pkg::diff33(rd_reg[63:32], y0_reg);
                    dz_reg    <= ppti_pkg::diff33(rd_reg[95:64], z0_reg);
                    tlast_reg <= rd_reg[127:96];
                    len2_reg  <= '0;
                    pos_reg   <= '0;
                    neg_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ppti_pkg::S_LEN;
                end
                ppti_pkg::S_LEN:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        if (cnt_reg <= 6'(ppti_pkg::SQ_TERMS))
                        begin
                            len2_reg <= len2_reg + prod_reg[65:0];
                        end
                        else if (prod_neg_reg)
                        begin
                            neg_reg <= neg_reg + prod_reg[65:0];
                        end
                        else
                        begin
                            pos_reg <= pos_reg + prod_reg[65:0];
                        end
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ppti_pkg::DOT_TERMS))
                    begin
                        state_reg <= ppti_pkg::S_CHECK;
                    end
                end
                ppti_pkg::S_CHECK:
                begin
                    if (len2_reg == '0)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= 1'b1;
                        time_out_reg <= '0;
                        progress_reg <= '0;
                        state_reg    <= ppti_pkg::S_IDLE;
                    end
                    else if (neg_reg >= pos_reg)
                    begin
                        p_reg     <= '0;
                        state_reg <= ppti_pkg::S_TOTS;
                    end
                    else if (dot >= len2_reg)
                    begin
                        p_reg     <= ppti_pkg::ONE_Q16;
                        state_reg <= ppti_pkg::S_TOTS;
                    end
                    else
                    begin
                        dv_rem_reg <= {1'b0, dot};
                        dv_div_reg <= len2_reg;
                        dv_low_reg <= '0;
                        dv_q_reg   <= '0;
                        cnt_reg    <= 6'(ppti_pkg::PDIV_STEPS);
                        state_reg  <= ppti_pkg::S_PDIV;
                    end
                end
                ppti_pkg::S_PDIV:
                begin
                    dv_rem_reg <= dv_rem_next;
                    dv_low_reg <= {dv_low_reg[30:0], 1'b0};
                    dv_q_reg   <= dv_q_next;
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        p_reg     <= {1'b0, dv_q_next[15:0]};
                        state_reg <= ppti_pkg::S_TOTS;
                    end
                end
                ppti_pkg::S_TOTS:
                begin
                    sq_src_reg  <= {2'b00, len2_reg};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= 6'(ppti_pkg::SQRT_STEPS);
                    state_reg   <= ppti_pkg::S_TOTR;
                end
                ppti_pkg::S_TOTR:
                begin
                    sq_src_reg  <= {sq_src_reg[65:0], 2'b00};
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= sq_root_next;
                    cnt_reg     <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        total_reg <= sq_root_next;
                        state_reg <= ppti_pkg::S_PD;
                    end
                end
                ppti_pkg::S_PD:
                begin
                    state_reg <= ppti_pkg::S_PD2;
                end
                ppti_pkg::S_PD2:
                begin
                    pd_reg    <= prod_reg[50:0];
                    prev_reg  <= '0;
                    i_reg     <= IW'(1);
                    addr_reg  <= AW'(1);
                    state_reg <= ppti_pkg::S_FI;
                end
                ppti_pkg::S_FI:
                begin
                    state_reg <= ppti_pkg::S_DI;
                end
                ppti_pkg::S_DI:
                begin
                    dx_reg    <= ppti_pkg::diff33(rd_reg[31:0], x0_reg);
                    dy_reg    <= ppti_pkg::diff33(rd_reg[63:32], y0_reg);
                    dz_reg    <= ppti_pkg::diff33(rd_reg[95:64], z0_reg);
                    tcur_reg  <= rd_reg[127:96];
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ppti_pkg::S_SQ;
                end
                ppti_pkg::S_SQ:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        acc_reg <= acc_reg + prod_reg[65:0];
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ppti_pkg::SQ_TERMS))
                    begin
                        state_reg <= ppti_pkg::S_DS;
                    end
                end
                ppti_pkg::S_DS:
                begin
                    sq_src_reg  <= {2'b00, acc_reg};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= 6'(ppti_pkg::SQRT_STEPS);
                    state_reg   <= ppti_pkg::S_DR;
                end
                ppti_pkg::S_DR:
                begin
                    sq_src_reg  <= {sq_src_reg[65:0], 2'b00};
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= sq_root_next;
                    cnt_reg     <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        cur_reg   <= sq_root_next;
                        state_reg <= ppti_pkg::S_CMP;
                    end
                end
                ppti_pkg::S_CMP:
                begin
                    if (pd_reg <= {1'b0, d2s})
                    begin
                        if (cur_reg > prev_reg)
                        begin
                            den_reg   <= d2s - d1s;
                            num_reg   <= (num_c > (d2s - d1s)) ? (d2s - d1s) : num_c;
                            dir_reg   <= (tcur_reg < tprev_reg);
                            dt_reg    <= (tcur_reg >= tprev_reg) ? (tcur_reg - tprev_reg)
                                                                 : (tprev_reg - tcur_reg);
                            state_reg <= ppti_pkg::S_IM0;
                        end
                        else
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= 1'b0;
                            time_out_reg <= tprev_reg;
                            progress_reg <= p_reg;
                            state_reg    <= ppti_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        tprev_reg <= tcur_reg;
                        if (i_reg == n_reg - IW'(1))
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= 1'b0;
                            time_out_reg <= tlast_reg;
                            progress_reg <= p_reg;
                            state_reg    <= ppti_pkg::S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            addr_reg  <= AW'(i_reg + IW'(1));
                            state_reg <= ppti_pkg::S_FI;
                        end
                    end
                end
                ppti_pkg::S_IM0:
                begin
                    state_reg <= ppti_pkg::S_IM1;
                end
                ppti_pkg::S_IM1:
                begin
                    lo_reg    <= prod_reg[63:0];
                    state_reg <= ppti_pkg::S_IM2;
                end
                ppti_pkg::S_IM2:
                begin
                    dv_rem_reg <= {17'd0, full[81:32]};
                    dv_div_reg <= {16'd0, den_reg};
                    dv_low_reg <= full[31:0];
                    dv_q_reg   <= '0;
                    cnt_reg    <= 6'(ppti_pkg::IDIV_STEPS);
                    state_reg  <= ppti_pkg::S_IDIV;
                end
                ppti_pkg::S_IDIV:
                begin
                    dv_rem_reg <= dv_rem_next;
                    dv_low_reg <= {dv_low_reg[30:0], 1'b0};
                    dv_q_reg   <= dv_q_next;
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= 1'b0;
                        time_out_reg <= dir_reg ? (tprev_reg - dv_q_next)
                                                : (tprev_reg + dv_q_next);
                        progress_reg <= p_reg;
                        state_reg    <= ppti_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ppti_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/path_progress_time_interpolator_tb.sv
// Testbench for the path progress time interpolator: random and directed items against a predictor.
module path_progress_time_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] time_val;
        logic [16:0] prog;
        logic        stat;
    } answer_t;

    class path_time_scoreboard;
        logic [31:0] px[64], py[64], pz[64], pt[64];
        logic [6:0]  count;
        bit          written[64];
        answer_t     pending[$];
        int          errors;

        function new();
            count = 0;
            errors = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function void enqueue(answer_t a);
            pending.insert(pending.size(), a);
        endfunction

        function logic [63:0] isqrt(logic [127:0] v);
            logic [63:0] res, t;
            res = 0;
            for (int b = 33; b >= 0; b--)
            begin
                t = res | (64'd1 << b);
                if (v >= 128'(t) * 128'(t)) res = t;
            end
            return res;
        endfunction

        function logic signed [127:0] sq_from_first(logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] z);
            logic signed [127:0] a, b, c;
            a = longint'(signed'(x)) - longint'(signed'(px[0]));
            b = longint'(signed'(y)) - longint'(signed'(py[0]));
            c = longint'(signed'(z)) - longint'(signed'(pz[0]));
            return a * a + b * b + c * c;
        endfunction

        function void note(logic op, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] t);
            int unsigned n, last;
            logic signed [127:0] dx, dy, dz, qx, qy, qz, len2, dot;
            logic [63:0] p, total, prev, cur, pd, d1s, d2s, num, den;
            logic [127:0] q;
            logic [31:0] t1, t2, tout;
            answer_t a;
            if (op == ppti_pkg::OP_LOAD)
            begin
                px[idx] = x; py[idx] = y; pz[idx] = z; pt[idx] = t;
                written[idx] = 1;
                return;
            end
            a = '{32'd0, 17'd0, 1'b1};
            n = (count > 64) ? 64 : count;
            if (n < 2)
            begin
                enqueue(a);
                return;
            end
            last = n - 1;
            dx = longint'(signed'(px[last])) - longint'(signed'(px[0]));
            dy = longint'(signed'(py[last])) - longint'(signed'(py[0]));
            dz = longint'(signed'(pz[last])) - longint'(signed'(pz[0]));
            len2 = dx * dx + dy * dy + dz * dz;
            if (len2 == 0)
            begin
                enqueue(a);
                return;
            end
            qx = longint'(signed'(x)) - longint'(signed'(px[0]));
            qy = longint'(signed'(y)) - longint'(signed'(py[0]));
            qz = longint'(signed'(z)) - longint'(signed'(pz[0]));
            dot = qx * dx + qy * dy + qz * dz;
            if (dot <= 0) p = 0;
            else if (dot >= len2) p = 64'd65536;
            else p = 64'((dot <<< 16) / len2);
            total = isqrt(len2);
            tout = pt[last];
            prev = 0;
            for (int unsigned i = 1; i < n; i++)
            begin
                cur = isqrt(sq_from_first(px[i], py[i], pz[i]));
                pd = p * total;
                if (pd <= (cur << 16))
                begin
                    t1 = pt[i - 1];
                    t2 = pt[i];
                    d1s = prev << 16;
                    d2s = cur << 16;
                    tout = t1;
                    if (d2s > d1s)
                    begin
                        num = (pd > d1s) ? pd - d1s : 0;
                        den = d2s - d1s;
                        if (num > den) num = den;
                        if (t2 >= t1)
                        begin
                            q = (128'(num) * 128'(t2 - t1)) / 128'(den);
                            tout = t1 + q[31:0];
                        end
                        else
                        begin
                            q = (128'(num) * 128'(t1 - t2)) / 128'(den);
                            tout = t1 - q[31:0];
                        end
                    end
                    break;
                end
                prev = cur;
            end
            a = '{tout, p[16:0], 1'b0};
            enqueue(a);
        endfunction

        function void check(logic [31:0] t, logic [16:0] p, logic s);
            answer_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: time %h progress %h status %b", t, p, s);
                return;
            end
            e = pending.pop_front();
            if (t !== e.time_val || p !== e.prog || s !== e.stat)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: time %h/%h progress %h/%h status %b/%b (exp/act)",
                             e.time_val, t, e.prog, p, e.stat, s);
            end
        endfunction
    endclass

    logic        clk, rst_n, start, busy, opcode, done, status;
    logic [5:0]  entry_index;
    logic [31:0] pos_x, pos_y, pos_z, stamp_time, time_out, prdata, pwdata;
    logic [16:0] progress;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;

    path_time_scoreboard sb;
    int burst_left;

    path_progress_time_interpolator dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check(time_out, progress, status);
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send(logic op, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic [31:0] t);
        start <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        stamp_time <= t;
        do @(posedge clk); while (busy);
        sb.note(op, idx, x, y, z, t);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_count(logic [6:0] v);
        settle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(ppti_pkg::REG_POINT_COUNT) << 2;
        pwdata <= {25'($urandom() >> 7), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.count = v;
        @(posedge clk);
    endtask

    task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send(ppti_pkg::OP_QUERY, 6'($urandom()), x, y, z, $urandom());
    endtask

    task automatic random_phase(logic [6:0] cnt);
        int unsigned n, k;
        logic [31:0] step, base;
        bit tidy;
        n = (cnt > 64) ? 64 : cnt;
        tidy = $urandom_range(0, 2) != 0;
        step = $urandom_range(1, 1 << 20);
        base = $urandom();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (sb.written[i] && i >= 8) continue;
            if (tidy)
                send(ppti_pkg::OP_LOAD, 6'(i), base + i * step + $urandom_range(0, 255),
                     $urandom_range(0, 4095), $urandom_range(0, 4095) - 2048,
                     i * 32'h0002_0000 + $urandom_range(0, 65535));
            else
                send(ppti_pkg::OP_LOAD, 6'(i), $urandom(), $urandom(), $urandom(),
                     $urandom());
        end
        set_count(cnt);
        k = (n > 8) ? 5 : 10;
        repeat (k)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if (n > 0)
                    send(ppti_pkg::OP_LOAD, 6'($urandom_range(0, n - 1)), $urandom(),
                         $urandom(), $urandom(), $urandom());
                else
                    send(ppti_pkg::OP_LOAD, 6'($urandom()), $urandom(), $urandom(),
                         $urandom(), $urandom());
            end
            else if (tidy)
                query(base + $urandom_range(0, n + 1) * step - step / 2 +
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535) - 32768);
            else
                query($urandom(), $urandom(), $urandom());
        end
    endtask

    initial
    begin
        logic [6:0] cnt;
        sb = new();
        burst_left = 4;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = ppti_pkg::OP_LOAD;
        entry_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        stamp_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        query(32'h0001_0000, 0, 0);
        set_count(7'd1);
        query(0, 0, 0);
        send(ppti_pkg::OP_LOAD, 6'd0, 0, 0, 0, 32'h0064_0000);
        send(ppti_pkg::OP_LOAD, 6'd1, 32'h0001_0000, 0, 0, 32'h006E_0000);
        send(ppti_pkg::OP_LOAD, 6'd2, 32'h0001_0000, 0, 0, 32'h0078_0000);
        send(ppti_pkg::OP_LOAD, 6'd3, 32'h0002_0000, 0, 0, 32'h0069_0000);
        set_count(7'd4);
        query(32'hFFFF_0000, 32'h0003_0000, 0);
        query(32'h0000_8000, 0, 32'h0001_0000);
        query(32'h0001_0000, 0, 0);
        query(32'h0001_8000, 32'hFFFF_0000, 0);
        query(32'h0005_0000, 0, 0);
        send(ppti_pkg::OP_LOAD, 6'd4, 0, 0, 0, 32'h0001_0000);
        set_count(7'd5);
        query(32'h0001_0000, 0, 0);
        send(ppti_pkg::OP_LOAD, 6'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFF);
        send(ppti_pkg::OP_LOAD, 6'd6, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send(ppti_pkg::OP_LOAD, 6'd63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'hFFFF_FFFF);
        set_count(7'd7);
        query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: cnt = 7'd2;
                1: cnt = 7'd0;
                2: cnt = 7'd64;
                3: cnt = 7'd127;
                4: cnt = 7'd1;
                5: cnt = 7'd3;
                default: cnt = 7'($urandom_range(2, 8));
            endcase
            random_phase(cnt);
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
